// ----- rtl/core/zvc_pkg.sv -----
// Shared types and constants for the zigzag varint codec.
`timescale 1ns / 1ps
package zvc_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned GROUP_W     = 7;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned REM_W       = VALUE_W - GROUP_W;
  localparam int unsigned LAST_SHIFT  = 28;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] LAST_BYTE_IDX = 3'd4;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] word;
    logic               malformed;
  } zvc_job_t;

  function automatic logic [VALUE_W-1:0] zig(input logic [VALUE_W-1:0] v);
    zig = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
  endfunction

  function automatic logic [VALUE_W-1:0] zag(input logic [VALUE_W-1:0] u);
    zag = {1'b0, u[VALUE_W-1:1]} ^ {VALUE_W{u[0]}};
  endfunction

endpackage

// ----- rtl/core/zvc_if.sv -----
// Channel interfaces for the zigzag varint codec.
`timescale 1ns / 1ps
interface zvc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [zvc_pkg::VALUE_W-1:0] value_in;
  logic [zvc_pkg::BYTE_W-1:0]        byte_in;

  modport source (output valid, req_type, value_in, byte_in, input ready);
  modport sink   (input valid, req_type, value_in, byte_in, output ready);
endinterface

interface zvc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [zvc_pkg::BYTE_W-1:0]        byte_out;
  logic                              last;
  logic signed [zvc_pkg::VALUE_W-1:0] value_out;
  logic                              malformed;

  modport source (output valid, kind, byte_out, last, value_out, malformed, input ready);
  modport sink   (input valid, kind, byte_out, last, value_out, malformed, output ready);
endinterface

// ----- rtl/core/zvc_front.sv -----
// Front end: accepts requests, zigzags encodes and gathers decode bytes.
`timescale 1ns / 1ps
module zvc_front (
  input  logic             clk,
  input  logic             rst_n,
  zvc_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             push,
  output zvc_pkg::zvc_job_t push_job
);

  logic [zvc_pkg::VALUE_W-1:0] accum_r, accum_nxt;
  logic [zvc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [zvc_pkg::VALUE_W-1:0] merged;
  logic [4:0]                  shamt;
  logic                        accept;
  logic                        more;
  logic                        at_last;
  logic                        done;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign more        = in_ch.byte_in[zvc_pkg::BYTE_W-1];
  assign at_last     = (count_r == zvc_pkg::LAST_BYTE_IDX);

  always_comb begin
    unique case (count_r)
      3'd0:    shamt = 5'd0;
      3'd1:    shamt = 5'd7;
      3'd2:    shamt = 5'd14;
      3'd3:    shamt = 5'd21;
      default: shamt = 5'd0;
    endcase
  end

  always_comb begin
    if (at_last) begin
      merged = accum_r | (zvc_pkg::VALUE_W'(in_ch.byte_in) << zvc_pkg::LAST_SHIFT);
    end else begin
      merged = accum_r |
               (zvc_pkg::VALUE_W'(in_ch.byte_in[zvc_pkg::GROUP_W-1:0]) << shamt);
    end
  end

  assign done = !more || at_last;

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (in_ch.req_type == zvc_pkg::REQ_ENCODE) begin
        push          = 1'b1;
        push_job.kind = zvc_pkg::KIND_BYTE;
        push_job.word = zvc_pkg::zig(in_ch.value_in);
      end else if (done) begin
        push               = 1'b1;
        push_job.kind      = zvc_pkg::KIND_VALUE;
        push_job.malformed = more;
        push_job.word      = more ? merged : zvc_pkg::zag(merged);
      end
    end
  end

  always_comb begin
    accum_nxt = accum_r;
    count_nxt = count_r;
    if (accept && in_ch.req_type == zvc_pkg::REQ_DECODE) begin
      if (done) begin
        accum_nxt = '0;
        count_nxt = '0;
      end else begin
        accum_nxt = merged;
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      count_r <= '0;
    end else begin
      accum_r <= accum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/zvc_queue.sv -----
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module zvc_queue #(
  parameter int unsigned DEPTH = zvc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  zvc_pkg::zvc_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output zvc_pkg::zvc_job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  zvc_pkg::zvc_job_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_MAX) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_MAX) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/core/zvc_back.sv -----
// Back end: emits encoded bytes one per cycle while out_ch is ready, and decoded values.
`timescale 1ns / 1ps
module zvc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  zvc_pkg::zvc_job_t q_head,
  output logic              pop,
  zvc_out_if.source         out_ch
);

  logic                             valid_r, valid_nxt;
  logic                             busy_r, busy_nxt;
  logic [zvc_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic                             kind_r, kind_nxt;
  logic [zvc_pkg::BYTE_W-1:0]       byte_r, byte_nxt;
  logic                             last_r, last_nxt;
  logic [zvc_pkg::VALUE_W-1:0]      value_r, value_nxt;
  logic                             bad_r, bad_nxt;
  logic                             can_load;
  logic [zvc_pkg::VALUE_W-1:0]      src;
  logic [zvc_pkg::REM_W-1:0]        rest;
  logic                             fin;

  assign out_ch.valid     = valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.byte_out  = byte_r;
  assign out_ch.last      = last_r;
  assign out_ch.value_out = value_r;
  assign out_ch.malformed = bad_r;

  assign can_load = !valid_r || out_ch.ready;
  assign pop      = can_load && !busy_r && q_not_empty;

  assign src  = busy_r ? zvc_pkg::VALUE_W'(rem_r) : q_head.word;
  assign rest = src[zvc_pkg::VALUE_W-1:zvc_pkg::GROUP_W];
  assign fin  = (rest == '0);

  always_comb begin
    valid_nxt = valid_r;
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    value_nxt = value_r;
    bad_nxt   = bad_r;
    if (can_load) begin
      valid_nxt = 1'b0;
      if (busy_r || (pop && q_head.kind == zvc_pkg::KIND_BYTE)) begin
        valid_nxt = 1'b1;
        kind_nxt  = zvc_pkg::KIND_BYTE;
        byte_nxt  = {!fin, src[zvc_pkg::GROUP_W-1:0]};
        last_nxt  = fin;
        value_nxt = '0;
        bad_nxt   = 1'b0;
        busy_nxt  = !fin;
        rem_nxt   = rest;
      end else if (pop) begin
        valid_nxt = 1'b1;
        kind_nxt  = zvc_pkg::KIND_VALUE;
        byte_nxt  = '0;
        last_nxt  = 1'b0;
        value_nxt = q_head.word;
        bad_nxt   = q_head.malformed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    value_r <= value_nxt;
    bad_r   <= bad_nxt;
  end

endmodule

// ----- rtl/core/zigzag_varint_codec_top.sv -----
// Top level of the zigzag varint codec for signed 32-bit integers.
//
// in_ch carries requests: req_type 0 encodes value_in, req_type 1 feeds one
// varint byte from byte_in to the decoder. out_ch carries results: kind 0 is
// one encoded byte (byte_out, last), kind 1 is a decoded value (value_out,
// malformed). Both channels complete a transaction when valid and ready are high.
// The front end takes one request per cycle while the job queue has room;
// a continuation byte other than the fifth only updates the decode accumulator
// and gives no result. A result is registered first in the job queue and then
// in the back end's output register. The back end drains the queue: an encode
// occupies it while it emits its 1 to 5 bytes, one per cycle while ready is
// high (bytes = groups of 7 bits in the zigzagged word), a decoded value only
// until it is loaded, so sustained throughput is set by the back end.
// Synchronous reset clears the decode state, the queue and the output valid
// flag. When the receiver holds ready low, the output register holds its
// transaction, the back end stops, and the front end keeps taking requests
// until the queue fills.
`timescale 1ns / 1ps
module zigzag_varint_codec_top #(
  parameter int unsigned QUEUE_DEPTH = zvc_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  zvc_in_if.sink    in_ch,
  zvc_out_if.source out_ch
);

  logic              push;
  zvc_pkg::zvc_job_t push_job;
  logic              q_full;
  logic              pop;
  logic              q_not_empty;
  zvc_pkg::zvc_job_t q_head;

  zvc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  zvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  zvc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

// ----- tb/tb_zigzag_varint_codec_top.sv -----
// Self-checking testbench for the zigzag varint codec: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_zigzag_varint_codec_top;

  localparam int unsigned REQ_TOTAL   = 270;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam logic [7:0]  CONT_BIT    = 8'h80;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_out;
    logic        last;
    logic [31:0] value_out;
    logic        malformed;
  } codec_result_t;

  typedef struct packed {
    logic          req;
    logic [31:0]   val;
    logic [7:0]    b;
    logic          typed;
    codec_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  zvc_in_if  in_ch ();
  zvc_out_if out_ch ();

  zigzag_varint_codec_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [31:0]   dec_word;
  logic [2:0]    dec_cnt;
  codec_result_t step_q [$];
  codec_result_t pending_q [$];
  stim_row_t     dir_tab [$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned req_count;
  int unsigned enc_count;
  int unsigned dec_count;
  int unsigned res_count;
  int unsigned bad_count;
  bit          in_steady;
  bit          out_steady;

  function automatic codec_result_t byte_res(input logic [7:0] b, input logic fin);
    codec_result_t r;
    r = '0;
    r.kind     = zvc_pkg::KIND_BYTE;
    r.byte_out = b;
    r.last     = fin;
    return r;
  endfunction

  function automatic codec_result_t word_res(input logic [31:0] w, input logic bad);
    codec_result_t r;
    r = '0;
    r.kind      = zvc_pkg::KIND_VALUE;
    r.value_out = w;
    r.malformed = bad;
    return r;
  endfunction

  function automatic void step_add(input codec_result_t r);
    step_q = {step_q, r};
  endfunction

  function automatic void pending_add(input codec_result_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic void codec_predict(input logic req, input logic [31:0] val,
                                        input logic [7:0] b);
    logic signed [31:0] sv;
    logic [31:0]        u;
    logic [6:0]         grp;
    step_q.delete();
    if (req == zvc_pkg::REQ_ENCODE) begin
      sv = val;
      u  = (sv <<< 1) ^ (sv >>> 31);
      do begin
        grp = u[6:0];
        u   = u >> 7;
        if (u == 0) step_add(byte_res({1'b0, grp}, 1'b1));
        else step_add(byte_res({1'b0, grp} | CONT_BIT, 1'b0));
      end while (u != 0);
    end else begin
      if (dec_cnt < 4) dec_word = dec_word | ({25'd0, b[6:0]} << (7 * dec_cnt));
      else dec_word = dec_word | {b[3:0], 28'd0};
      if (!b[7]) begin
        step_add(word_res((dec_word >> 1) ^ (32'd0 - {31'd0, dec_word[0]}), 1'b0));
        dec_word = '0;
        dec_cnt  = '0;
      end else if (dec_cnt == 4) begin
        step_add(word_res(dec_word, 1'b1));
        dec_word = '0;
        dec_cnt  = '0;
      end else begin
        dec_cnt = dec_cnt + 3'd1;
      end
    end
  endfunction

  task automatic send_req(input logic req, input logic [31:0] val, input logic [7:0] b,
                          input logic typed, input codec_result_t typed_res);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value_in <= val;
    in_ch.byte_in  <= b;
    do @(posedge clk); while (!in_ch.ready);
    codec_predict(req, val, b);
    if (typed) pending_add(typed_res);
    else foreach (step_q[i]) pending_add(step_q[i]);
    req_count++;
    if (req == zvc_pkg::REQ_ENCODE) enc_count++;
    else dec_count++;
    if (req_count % 40 == 0) in_steady = ~in_steady;
  endtask

  function automatic void add_row(input logic req, input logic [31:0] val,
                                  input logic [7:0] b, input logic typed,
                                  input codec_result_t res);
    stim_row_t row;
    row.req   = req;
    row.val   = val;
    row.b     = b;
    row.typed = typed;
    row.res   = res;
    dir_tab = {dir_tab, row};
  endfunction

  task automatic send_decode_run(input int unsigned n, input bit overlong);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      if (overlong || k < n - 1) b = b | CONT_BIT;
      else b = b & ~CONT_BIT;
      send_req(zvc_pkg::REQ_DECODE, $urandom, b, 1'b0, '0);
      if (k == 0 && $urandom_range(0, 4) == 0)
        send_req(zvc_pkg::REQ_ENCODE, $urandom >> $urandom_range(0, 31), 8'($urandom),
                 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    codec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_count++;
      if (out_ch.malformed) bad_count++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: kind %0d byte_out %0h value_out %0h",
               out_ch.kind, out_ch.byte_out, out_ch.value_out);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.byte_out !== want.byte_out) begin
          $error("byte_out: expected %0h, actual %0h", want.byte_out, out_ch.byte_out);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_ch.last);
          errors++;
        end
        if (out_ch.value_out !== want.value_out) begin
          $error("value_out: expected %0h, actual %0h", want.value_out, out_ch.value_out);
          errors++;
        end
        if (out_ch.malformed !== want.malformed) begin
          $error("malformed: expected %0d, actual %0d", want.malformed, out_ch.malformed);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ch.ready = 1'b0;
    taken        = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % 50 == 0) out_steady = ~out_steady;
    end
  end

  initial begin
    int unsigned pick;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = zvc_pkg::REQ_ENCODE;
    in_ch.value_in = '0;
    in_ch.byte_in  = '0;
    dec_word       = '0;
    dec_cnt        = '0;
    errors         = 0;
    cycles         = 0;
    req_count      = 0;
    enc_count      = 0;
    dec_count      = 0;
    res_count      = 0;
    bad_count      = 0;
    in_steady      = 1'b0;
    out_steady     = 1'b0;

    add_row(zvc_pkg::REQ_DECODE, 32'hFFFF_FFFF, 8'h00, 1'b1, word_res(32'h0000_0000, 1'b0));
    add_row(zvc_pkg::REQ_ENCODE, 32'h0000_0000, 8'hFF, 1'b1, byte_res(8'h00, 1'b1));
    add_row(zvc_pkg::REQ_ENCODE, 32'hFFFF_FFFF, 8'h00, 1'b1, byte_res(8'h01, 1'b1));
    add_row(zvc_pkg::REQ_ENCODE, 32'h7FFF_FFFF, 8'h00, 1'b0, '0);
    add_row(zvc_pkg::REQ_ENCODE, 32'h8000_0000, 8'h00, 1'b0, '0);
    add_row(zvc_pkg::REQ_ENCODE, 32'h0000_0040, 8'h00, 1'b0, '0);
    for (int k = 0; k < 4; k++) add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'hFF, 1'b0, '0);
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'hFF, 1'b1, word_res(32'hFFFF_FFFF, 1'b1));
    for (int k = 0; k < 4; k++) add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'h80, 1'b0, '0);
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'h7F, 1'b1, word_res(32'h7800_0000, 1'b0));
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'h85, 1'b0, '0);
    add_row(zvc_pkg::REQ_ENCODE, 32'h0000_0005, 8'h00, 1'b0, '0);
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'h01, 1'b0, '0);
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'h7F, 1'b1, word_res(32'hFFFF_FFC0, 1'b0));
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'hFE, 1'b0, '0);
    for (int k = 0; k < 3; k++) add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'hFF, 1'b0, '0);
    add_row(zvc_pkg::REQ_DECODE, 32'h0, 8'h0F, 1'b1, word_res(32'h7FFF_FFFF, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_req(dir_tab[i].req, dir_tab[i].val, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].res);

    while (req_count < REQ_TOTAL) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        send_req(zvc_pkg::REQ_ENCODE,
                 ($urandom_range(0, 1) != 0) ? ~($urandom >> $urandom_range(0, 31))
                                             : ($urandom >> $urandom_range(0, 31)),
                 8'($urandom), 1'b0, '0);
      end else if (pick <= 7) begin
        send_decode_run($urandom_range(1, 5), 1'b0);
      end else if (pick == 8) begin
        send_decode_run(5, 1'b1);
      end else begin
        send_req(zvc_pkg::REQ_DECODE, $urandom, 8'($urandom), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests: %0d encodes, %0d decode bytes", req_count, enc_count,
             dec_count);
    $display("Checked %0d results, %0d of them overlong varints", res_count, bad_count);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/zvc_pkg.sv
rtl/core/zvc_if.sv
rtl/core/zvc_front.sv
rtl/core/zvc_queue.sv
rtl/core/zvc_back.sv
rtl/core/zigzag_varint_codec_top.sv
tb/tb_zigzag_varint_codec_top.sv
